### design/amrfp_pkg.sv
// amrfp_pkg: types and constants for the audio module response frame parser.
// No dependencies.
package amrfp_pkg;

  localparam logic [7:0] BYTE_START   = 8'h7E;
  localparam logic [7:0] BYTE_VERSION = 8'hFF;
  localparam logic [7:0] BYTE_LENGTH  = 8'h06;
  localparam logic [7:0] BYTE_END     = 8'hEF;

  localparam logic [7:0] CMD_FIN_LO   = 8'h3C;
  localparam logic [7:0] CMD_FIN_HI   = 8'h3E;
  localparam logic [7:0] CMD_INSERT   = 8'h3A;
  localparam logic [7:0] CMD_REMOVE   = 8'h3B;
  localparam logic [7:0] CMD_ONLINE   = 8'h3F;
  localparam logic [7:0] CMD_DEV_ERR  = 8'h40;
  localparam logic [7:0] CMD_ACK      = 8'h41;
  localparam logic [7:0] CMD_FB_LO    = 8'h42;
  localparam logic [7:0] CMD_FB_GAP   = 8'h4A;
  localparam logic [7:0] CMD_FB_HI    = 8'h4F;

  typedef enum logic [3:0] {
    EV_FINISHED    = 4'd0,
    EV_USB_IN      = 4'd1,
    EV_CARD_IN     = 4'd2,
    EV_USB_OUT     = 4'd3,
    EV_CARD_OUT    = 4'd4,
    EV_BOTH_ONLINE = 4'd5,
    EV_USB_ONLINE  = 4'd6,
    EV_CARD_ONLINE = 4'd7,
    EV_DEV_ERROR   = 4'd8,
    EV_FEEDBACK    = 4'd9,
    EV_ACK         = 4'd10,
    EV_FRAME_ERROR = 4'd11
  } event_kind_e;

  // next frame byte expected; one-hot
  typedef enum logic [9:0] {
    POS_HUNT = 10'b00_0000_0001,
    POS_VER  = 10'b00_0000_0010,
    POS_LEN  = 10'b00_0000_0100,
    POS_CMD  = 10'b00_0000_1000,
    POS_FB   = 10'b00_0001_0000,
    POS_PHI  = 10'b00_0010_0000,
    POS_PLO  = 10'b00_0100_0000,
    POS_CHI  = 10'b00_1000_0000,
    POS_CLO  = 10'b01_0000_0000,
    POS_END  = 10'b10_0000_0000
  } frame_pos_e;

  typedef struct packed {
    event_kind_e kind;
    logic [15:0] param;
    logic [7:0]  cmd;
  } event_word_t;

endpackage

### design/amrfp_if.sv
// amrfp_if: valid/ready channel interfaces for the frame parser.
// amrfp_byte_if carries received bytes, amrfp_evt_if carries event words.
interface amrfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface amrfp_evt_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_kind;
  logic [15:0] parameter_value;
  logic [7:0]  command_code;

  modport source (output valid, output event_kind, output parameter_value,
                  output command_code, input ready);
  modport sink   (input valid, input event_kind, input parameter_value,
                  input command_code, output ready);
endinterface

### design/audio_module_response_frame_parser_top.sv
// An event word is registered in the output register, or in the skid register.
// Throughput: one byte per cycle while the skid register is empty; an output
// register plus a skid register keep in_i.ready high while one event word waits.
// Reset (rst_ni low, async): parser hunts for a start byte, sums and the last
// command clear to zero, both output registers empty.
// Depends on amrfp_pkg and amrfp_if.
module audio_module_response_frame_parser_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  amrfp_byte_if.sink          in_i,
  amrfp_evt_if.source         out_o
);
  import amrfp_pkg::*;

  frame_pos_e  pos_q, pos_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] param_q, param_d;
  logic [15:0] chk_q, chk_d;
  logic [7:0]  last_q, last_d;

  event_word_t out_q, out_d, skid_q, skid_d, res;
  logic        out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic        res_valid, accept, push;
  logic [7:0]  b;
  logic        usb, card;

  assign in_i.ready = !skid_valid_q;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.byte_in;
  assign usb        = param_q[0];
  assign card       = param_q[1];

  always_comb begin
    pos_d     = pos_q;
    sum_d     = sum_q;
    cmd_d     = cmd_q;
    param_d   = param_q;
    chk_d     = chk_q;
    last_d    = last_q;
    res_valid = 1'b0;
    res       = '{kind: EV_FRAME_ERROR, param: 16'h0000, cmd: last_q};
    if (accept) begin
      case (pos_q)
        POS_VER: begin
          if (b != BYTE_VERSION) begin
            res_valid = 1'b1;
            pos_d     = POS_HUNT;
          end else begin
            sum_d = sum_q + {8'h00, b};
            pos_d = POS_LEN;
          end
        end
        POS_LEN: begin
          if (b != BYTE_LENGTH) begin
            res_valid = 1'b1;
            pos_d     = POS_HUNT;
          end else begin
            sum_d = sum_q + {8'h00, b};
            pos_d = POS_CMD;
          end
        end
        POS_CMD: begin
          cmd_d = b;
          sum_d = sum_q + {8'h00, b};
          pos_d = POS_FB;
        end
        POS_FB: begin
          sum_d = sum_q + {8'h00, b};
          pos_d = POS_PHI;
        end
        POS_PHI: begin
          param_d = {b, 8'h00};
          sum_d   = sum_q + {8'h00, b};
          pos_d   = POS_PLO;
        end
        POS_PLO: begin
          param_d = {param_q[15:8], b};
          sum_d   = sum_q + {8'h00, b};
          pos_d   = POS_CHI;
        end
        POS_CHI: begin
          chk_d = {b, 8'h00};
          pos_d = POS_CLO;
        end
        POS_CLO: begin
          chk_d = {chk_q[15:8], b};
          pos_d = POS_END;
        end
        POS_END: begin
          pos_d = POS_HUNT;
          if (b != BYTE_END || chk_q != 16'(16'h0000 - sum_q)) begin
            res_valid = 1'b1;
          end else if (cmd_q == CMD_ACK) begin
            res_valid = 1'b1;
            res       = '{kind: EV_ACK, param: param_q, cmd: cmd_q};
          end else begin
            last_d    = cmd_q;
            res_valid = 1'b1;
            res       = '{kind: EV_FRAME_ERROR, param: 16'h0000, cmd: cmd_q};
            case (cmd_q) inside
              [CMD_FIN_LO:CMD_FIN_HI]: res.kind = EV_FINISHED;
              CMD_INSERT: begin
                res_valid = usb || card;
                res.kind  = usb ? EV_USB_IN : EV_CARD_IN;
              end
              CMD_REMOVE: begin
                res_valid = usb || card;
                res.kind  = usb ? EV_USB_OUT : EV_CARD_OUT;
              end
              CMD_ONLINE: begin
                res_valid = usb || card;
                res.kind  = (usb && card) ? EV_BOTH_ONLINE :
                            usb ? EV_USB_ONLINE : EV_CARD_ONLINE;
              end
              CMD_DEV_ERR: res.kind = EV_DEV_ERROR;
              [CMD_FB_LO:CMD_FB_HI]: begin
                if (cmd_q != CMD_FB_GAP) res.kind = EV_FEEDBACK;
              end
              default: res.kind = EV_FRAME_ERROR;
            endcase
            if (res.kind != EV_FRAME_ERROR) res.param = param_q;
          end
        end
        default: begin
          if (b == BYTE_START) begin
            sum_d = 16'h0000;
            pos_d = POS_VER;
          end else begin
            pos_d = POS_HUNT;
          end
        end
      endcase
    end
  end

  // output register with skid
  assign push = accept && res_valid;

  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (!out_valid_q || out_o.ready) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res;
        out_valid_d = push;
      end
    end else if (push) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= POS_HUNT;
      sum_q        <= 16'h0000;
      cmd_q        <= 8'h00;
      param_q      <= 16'h0000;
      chk_q        <= 16'h0000;
      last_q       <= 8'h00;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      sum_q        <= sum_d;
      cmd_q        <= cmd_d;
      param_q      <= param_d;
      chk_q        <= chk_d;
      last_q       <= last_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.event_kind      = out_q.kind;
  assign out_o.parameter_value = out_q.param;
  assign out_o.command_code    = out_q.cmd;

endmodule

### tb/tb_audio_module_response_frame_parser_top.sv
// Testbench for audio_module_response_frame_parser_top: byte stream in, event words out.
// It predicts every event word and checks it field by field, with random idling on both sides.
// Depends on amrfp_pkg, amrfp_if and the top level.
module tb_audio_module_response_frame_parser_top;
  import amrfp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int FRAMES_PER_PHASE = 44;

  typedef enum int {
    FLAW_NONE,
    FLAW_VERSION,
    FLAW_LENGTH,
    FLAW_CHECKSUM,
    FLAW_END,
    FLAW_TRUNCATED
  } frame_flaw_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  amrfp_byte_if bif ();
  amrfp_evt_if  eif ();

  audio_module_response_frame_parser_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (bif),
    .out_o  (eif)
  );

  always #4 clk_i = ~clk_i;

  // parser model state
  frame_pos_e  frame_pos;
  logic [15:0] frame_sum;
  logic [7:0]  frame_cmd;
  logic [15:0] frame_param;
  logic [15:0] frame_chk;
  logic [7:0]  last_cmd;

  event_word_t pending_events[$];
  int          mismatch_count;
  int          src_idle_pct;
  int          sink_stall_pct;
  int          quiet_cycles;

  function automatic void framing_error(output event_word_t ev);
    frame_pos = POS_HUNT;
    ev.kind   = EV_FRAME_ERROR;
    ev.param  = '0;
    ev.cmd    = last_cmd;
  endfunction

  function automatic bit classify_frame(output event_word_t ev);
    logic usb;
    logic card;
    usb            = frame_param[0];
    card           = frame_param[1];
    ev.param       = frame_param;
    ev.cmd         = frame_cmd;
    ev.kind        = EV_FRAME_ERROR;
    classify_frame = 1'b1;
    if (frame_cmd == CMD_ACK) begin
      ev.kind = EV_ACK;
      return 1'b1;
    end
    last_cmd = frame_cmd;
    if (frame_cmd >= CMD_FIN_LO && frame_cmd <= CMD_FIN_HI) begin
      ev.kind = EV_FINISHED;
    end else if (frame_cmd == CMD_INSERT) begin
      if (usb) ev.kind = EV_USB_IN;
      else if (card) ev.kind = EV_CARD_IN;
      else classify_frame = 1'b0;
    end else if (frame_cmd == CMD_REMOVE) begin
      if (usb) ev.kind = EV_USB_OUT;
      else if (card) ev.kind = EV_CARD_OUT;
      else classify_frame = 1'b0;
    end else if (frame_cmd == CMD_ONLINE) begin
      if (usb && card) ev.kind = EV_BOTH_ONLINE;
      else if (usb) ev.kind = EV_USB_ONLINE;
      else if (card) ev.kind = EV_CARD_ONLINE;
      else classify_frame = 1'b0;
    end else if (frame_cmd == CMD_DEV_ERR) begin
      ev.kind = EV_DEV_ERROR;
    end else if (frame_cmd >= CMD_FB_LO && frame_cmd <= CMD_FB_HI && frame_cmd != CMD_FB_GAP) begin
      ev.kind = EV_FEEDBACK;
    end else begin
      ev.param = '0;
    end
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, output event_word_t ev);
    ev         = '0;
    parse_byte = 1'b0;
    case (frame_pos)
      POS_VER: if (b != BYTE_VERSION) begin
        framing_error(ev);
        return 1'b1;
      end
      POS_LEN: if (b != BYTE_LENGTH) begin
        framing_error(ev);
        return 1'b1;
      end
      POS_CMD: frame_cmd = b;
      POS_FB: ;
      POS_PHI: frame_param = {b, 8'h00};
      POS_PLO: frame_param[7:0] = b;
      POS_CHI: begin
        frame_chk = {b, 8'h00};
        frame_pos = POS_CLO;
        return 1'b0;
      end
      POS_CLO: begin
        frame_chk[7:0] = b;
        frame_pos      = POS_END;
        return 1'b0;
      end
      POS_END: begin
        frame_pos = POS_HUNT;
        if (b != BYTE_END || 16'(frame_chk + frame_sum) != 16'h0000) begin
          framing_error(ev);
          return 1'b1;
        end
        return classify_frame(ev);
      end
      default: begin
        frame_pos = POS_HUNT;
        if (b == BYTE_START) begin
          frame_sum = '0;
          frame_pos = POS_VER;
        end
        return 1'b0;
      end
    endcase
    frame_sum = 16'(frame_sum + b);
    frame_pos = frame_pos_e'(frame_pos << 1);
  endfunction

  // entered and left at a falling edge; valid stays high for a following word
  task automatic send_byte(input logic [7:0] b);
    event_word_t ev;
    while ($urandom_range(99) < src_idle_pct) begin
      bif.valid <= 1'b0;
      @(negedge clk_i);
    end
    bif.valid   <= 1'b1;
    bif.byte_in <= b;
    do @(posedge clk_i); while (!bif.ready);
    if (parse_byte(b, ev)) pending_events.push_back(ev);
    @(negedge clk_i);
  endtask

  task automatic send_frame(input logic [7:0] cmd, input logic [15:0] param,
                            input logic [7:0] fb, input frame_flaw_e flaw);
    logic [7:0]  fr[10];
    logic [15:0] sum;
    int          len;
    fr  = '{BYTE_START, BYTE_VERSION, BYTE_LENGTH, cmd, fb, param[15:8], param[7:0],
            8'h00, 8'h00, BYTE_END};
    sum = '0;
    for (int i = 1; i <= 6; i++) sum = 16'(sum + fr[i]);
    sum   = 16'(16'h0000 - sum);
    fr[7] = sum[15:8];
    fr[8] = sum[7:0];
    len   = 10;
    case (flaw)
      FLAW_VERSION:   fr[1] = fr[1] ^ 8'($urandom_range(1, 255));
      FLAW_LENGTH:    fr[2] = fr[2] ^ 8'($urandom_range(1, 255));
      FLAW_CHECKSUM:  fr[$urandom_range(7, 8)] ^= 8'($urandom_range(1, 255));
      FLAW_END:       fr[9] = fr[9] ^ 8'($urandom_range(1, 255));
      FLAW_TRUNCATED: len = $urandom_range(1, 9);
      default: ;
    endcase
    for (int i = 0; i < len; i++) send_byte(fr[i]);
  endtask

  task automatic test_header_errors();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(BYTE_START);
    send_byte(8'h00);
    // a start byte in the length slot must not open a new frame
    send_byte(BYTE_START);
    send_byte(BYTE_VERSION);
    send_byte(BYTE_START);
  endtask

  task automatic test_ack_and_unknown();
    send_frame(CMD_ACK, 16'hFFFF, 8'h00, FLAW_NONE);
    send_frame(CMD_FB_GAP, 16'hABCD, 8'hFF, FLAW_NONE);
  endtask

  task automatic test_random_frames();
    logic [7:0]  cmd;
    logic [15:0] param;
    int          r;
    frame_flaw_e flaw;
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct   = (ph == 0) ? 21 : (ph == 1) ? 57 : 0;
      sink_stall_pct = (ph == 0) ? 57 : (ph == 1) ? 21 : 0;
      for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
        if ($urandom_range(99) < 15)
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
        cmd = ($urandom_range(99) < 75) ? 8'($urandom_range(8'h3A, 8'h4F)) : 8'($urandom);
        r   = $urandom_range(99);
        if (r < 30) param = 16'($urandom_range(0, 3));
        else if (r < 40) param = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        else param = 16'($urandom);
        flaw = ($urandom_range(99) < 80) ? FLAW_NONE
                                         : frame_flaw_e'($urandom_range(FLAW_VERSION,
                                                                        FLAW_TRUNCATED));
        send_frame(cmd, param, 8'($urandom), flaw);
      end
    end
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) eif.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    event_word_t exp_ev;
    if (rst_ni && eif.valid && eif.ready) begin
      if (pending_events.size() == 0) begin
        $error("unexpected event word: kind %0d param %h cmd %h",
               eif.event_kind, eif.parameter_value, eif.command_code);
        mismatch_count++;
      end else begin
        exp_ev = pending_events.pop_front();
        if (eif.event_kind !== exp_ev.kind) begin
          $error("event_kind: expected %0d, got %0d", exp_ev.kind, eif.event_kind);
          mismatch_count++;
        end
        if (eif.parameter_value !== exp_ev.param) begin
          $error("parameter_value: expected %h, got %h", exp_ev.param, eif.parameter_value);
          mismatch_count++;
        end
        if (eif.command_code !== exp_ev.cmd) begin
          $error("command_code: expected %h, got %h", exp_ev.cmd, eif.command_code);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((bif.valid && bif.ready) || (eif.valid && eif.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL audio_module_response_frame_parser_top");
        $finish;
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    bif.valid      = 1'b0;
    bif.byte_in    = '0;
    eif.ready      = 1'b0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    src_idle_pct   = 21;
    sink_stall_pct = 57;
    frame_pos      = POS_HUNT;
    frame_sum      = '0;
    frame_cmd      = '0;
    frame_param    = '0;
    frame_chk      = '0;
    last_cmd       = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_header_errors();
    test_ack_and_unknown();
    test_random_frames();
    bif.valid <= 1'b0;

    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS audio_module_response_frame_parser_top");
    end else begin
      $display("FAIL audio_module_response_frame_parser_top");
    end
    $finish;
  end

endmodule

### files.f
design/amrfp_pkg.sv
design/amrfp_if.sv
design/audio_module_response_frame_parser_top.sv
tb/tb_audio_module_response_frame_parser_top.sv
